// ===== design/vrf_pkg.sv =====
// shared types, widths and codes for the rectangle fill video memory
`default_nettype none
package vrf_pkg;

    localparam int MEM_WIDTH_DEF  = 1024;
    localparam int MEM_HEIGHT_DEF = 512;

    localparam int X_W      = 11;
    localparam int Y_W      = 10;
    localparam int PX_W     = 10;
    localparam int PY_W     = 9;
    localparam int COLOUR_W = 16;
    localparam int STATUS_W = 2;

    localparam logic ACT_FILL = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FILL_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FILL_REJ  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 2'd2;

    typedef struct packed {
        logic [X_W-1:0]      x0;
        logic [Y_W-1:0]      y0;
        logic [X_W-1:0]      x1;
        logic [Y_W-1:0]      y1;
        logic [COLOUR_W-1:0] colour;
    } t_fill_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_walk_stat;

endpackage
`default_nettype wire

// ===== design/vrf_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none
module vrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/vrf_walker.sv =====
// rectangle walker: one pixel write address per cycle over a clipped rectangle
`default_nettype none
module vrf_walker #(
    parameter int MEM_WIDTH  = vrf_pkg::MEM_WIDTH_DEF,
    parameter int MEM_HEIGHT = vrf_pkg::MEM_HEIGHT_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_start,
    input  wire vrf_pkg::t_fill_req                         i_req,
    output vrf_pkg::t_walk_stat                             o_stat,
    output logic                                            o_we,
    output logic [$clog2(MEM_WIDTH*MEM_HEIGHT)-1:0]         o_waddr,
    output logic [vrf_pkg::COLOUR_W-1:0]                    o_wdata
);
    import vrf_pkg::*;

    localparam int AW = $clog2(MEM_WIDTH*MEM_HEIGHT);

    logic                r_busy;
    logic                r_done;
    logic [X_W-1:0]      r_x;
    logic [X_W-1:0]      r_x0;
    logic [X_W-1:0]      r_x1;
    logic [Y_W-1:0]      r_y;
    logic [Y_W-1:0]      r_y1;
    logic [AW-1:0]       r_row_base;
    logic [COLOUR_W-1:0] r_colour;

    logic [X_W-1:0] w_x_next;
    logic [Y_W-1:0] w_y_next;
    logic           w_last_x;
    logic           w_last_y;
    logic           w_empty;

    assign w_x_next = r_x + X_W'(1);
    assign w_y_next = r_y + Y_W'(1);
    assign w_last_x = (w_x_next == r_x1);
    assign w_last_y = (w_y_next == r_y1);
    assign w_empty  = (i_req.x0 == i_req.x1) || (i_req.y0 == i_req.y1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                if (w_empty) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy && w_last_x && w_last_y) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x        <= i_req.x0;
            r_x0       <= i_req.x0;
            r_x1       <= i_req.x1;
            r_y        <= i_req.y0;
            r_y1       <= i_req.y1;
            r_colour   <= i_req.colour;
            r_row_base <= AW'(i_req.y0 * MEM_WIDTH);
        end else if (r_busy) begin
            if (w_last_x) begin
                r_x        <= r_x0;
                r_y        <= w_y_next;
                r_row_base <= r_row_base + AW'(MEM_WIDTH);
            end else begin
                r_x <= w_x_next;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_we        = r_busy;
    assign o_waddr     = r_row_base + AW'(r_x);
    assign o_wdata     = r_colour;

`ifndef SYNTHESIS
    a_walk_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_x < r_x1) && (r_y < r_y1))
        else $error("walker outside rectangle");
    a_walk_in_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_x < X_W'(MEM_WIDTH)) && (r_y < Y_W'(MEM_HEIGHT)))
        else $error("walker outside memory");
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("walker done while still writing");
`endif

endmodule
`default_nettype wire

// ===== design/vram_rectangle_fill.sv =====
// top level: command sequencer, pixel memory and result register
// a read passes through S_READ and S_DONE before its result is registered; a fill
// walks its clipped area through the single memory write port at one pixel per cycle
// a rejected fill goes straight to S_DONE; one item is worked on at a time
// synchronous active-low reset clears control state only; pixel contents stay
// undefined until written and there is no clearing pass
`default_nettype none
module vram_rectangle_fill #(
    parameter int MEM_WIDTH  = vrf_pkg::MEM_WIDTH_DEF,
    parameter int MEM_HEIGHT = vrf_pkg::MEM_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [vrf_pkg::X_W-1:0]       i_left,
    input  wire logic [vrf_pkg::Y_W-1:0]       i_top,
    input  wire logic [vrf_pkg::X_W-1:0]       i_right,
    input  wire logic [vrf_pkg::Y_W-1:0]       i_bottom,
    input  wire logic [vrf_pkg::COLOUR_W-1:0]  i_colour,
    input  wire logic [vrf_pkg::PX_W-1:0]      i_pixel_x,
    input  wire logic [vrf_pkg::PY_W-1:0]      i_pixel_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [vrf_pkg::STATUS_W-1:0]       o_status,
    output logic [vrf_pkg::COLOUR_W-1:0]       o_read_pixel
);
    import vrf_pkg::*;

    localparam int DEPTH = MEM_WIDTH * MEM_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [X_W-1:0] W_X = X_W'(MEM_WIDTH);
    localparam logic [Y_W-1:0] H_Y = Y_W'(MEM_HEIGHT);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_FILL, S_DONE} t_state;

    t_state              r_state;
    logic                r_rd_ok;
    logic [STATUS_W-1:0] r_status;
    logic [COLOUR_W-1:0] r_pixel;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [COLOUR_W-1:0] r_out_pixel;

    logic          w_accept;
    logic          w_is_read;
    logic          w_reject;
    logic          w_rd_ok;
    logic          w_start;
    logic [AW-1:0] w_raddr;
    t_fill_req     w_req;
    t_walk_stat    w_stat;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [COLOUR_W-1:0] w_wdata;
    logic [COLOUR_W-1:0] w_rdata;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_read  = (i_action == ACT_READ);

    assign w_reject = (i_top > i_bottom) || (i_left > i_right) ||
                      (i_top >= H_Y) || (i_left >= W_X);
    assign w_rd_ok  = (X_W'(i_pixel_x) < W_X) && (Y_W'(i_pixel_y) < H_Y);
    assign w_raddr  = AW'(i_pixel_y * MEM_WIDTH + i_pixel_x);
    assign w_start  = w_accept && !w_is_read && !w_reject;

    assign w_req.x0     = i_left;
    assign w_req.y0     = i_top;
    assign w_req.x1     = (i_right > W_X) ? W_X : i_right;
    assign w_req.y1     = (i_bottom > H_Y) ? H_Y : i_bottom;
    assign w_req.colour = i_colour;

    vrf_walker #(
        .MEM_WIDTH  (MEM_WIDTH),
        .MEM_HEIGHT (MEM_HEIGHT)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_stat  (w_stat),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata)
    );

    vrf_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept && w_is_read && w_rd_ok),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pixel <= '0;
                        if (w_is_read) begin
                            r_rd_ok  <= w_rd_ok;
                            r_status <= ST_READ_OK;
                            r_state  <= S_READ;
                        end else if (w_reject) begin
                            r_status <= ST_FILL_REJ;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_FILL_DONE;
                            r_state  <= S_FILL;
                        end
                    end
                end
                S_READ: begin
                    r_pixel <= r_rd_ok ? w_rdata : '0;
                    r_state <= S_DONE;
                end
                S_FILL: begin
                    if (w_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_pixel  <= r_pixel;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_pixel = r_out_pixel;

`ifndef SYNTHESIS
    a_write_only_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_FILL))
        else $error("pixel write outside a fill");
    a_idle_walker_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_stat.busy && !w_stat.done)
        else $error("walker active while taking items");
    a_fill_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_READ_OK)) |-> (o_read_pixel == '0))
        else $error("fill result carries pixel data");
    a_fill_reaches_walker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && w_start) |=> (r_state == S_FILL))
        else $error("fill started without entering fill state");
`endif

endmodule
`default_nettype wire

// ===== bench/vram_rectangle_fill_tb.sv =====
// self-checking bench for the rectangle fill video memory, with a shadow copy of the pixels
`default_nettype none
module vram_rectangle_fill_tb;
    import vrf_pkg::*;

    localparam int MEM_W       = MEM_WIDTH_DEF;
    localparam int MEM_H       = MEM_HEIGHT_DEF;
    localparam int MEM_SIZE    = MEM_W * MEM_H;
    localparam int RANDOM_CMDS = 1400;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 2_000_000;

    typedef struct packed {
        logic                action;
        logic [X_W-1:0]      left;
        logic [Y_W-1:0]      top;
        logic [X_W-1:0]      right;
        logic [Y_W-1:0]      bottom;
        logic [COLOUR_W-1:0] colour;
        logic [PX_W-1:0]     pixel_x;
        logic [PY_W-1:0]     pixel_y;
    } vram_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COLOUR_W-1:0] pixel;
    } vram_res_t;

    class vram_shadow;
        bit [COLOUR_W-1:0] pixels [MEM_SIZE];
        bit                painted [MEM_SIZE];
        vram_res_t         awaited [$];
        int                n_reads, n_drawn, n_refused, n_checked, errors;
        longint            n_pixels;

        function void note_command(vram_cmd_t c);
            vram_res_t r;
            int x0, y0, x1, y1, x, y;
            r.pixel = '0;
            if (c.action == ACT_READ) begin
                r.status = ST_READ_OK;
                if (c.pixel_x < MEM_W && c.pixel_y < MEM_H)
                    r.pixel = pixels[c.pixel_y * MEM_W + c.pixel_x];
                n_reads++;
            end else begin
                x0 = c.left;
                y0 = c.top;
                x1 = c.right;
                y1 = c.bottom;
                if (x0 > x1 || y0 > y1 || x0 >= MEM_W || y0 >= MEM_H) begin
                    r.status = ST_FILL_REJ;
                    n_refused++;
                end else begin
                    if (x1 > MEM_W) x1 = MEM_W;
                    if (y1 > MEM_H) y1 = MEM_H;
                    for (y = y0; y < y1; y++) begin
                        for (x = x0; x < x1; x++) begin
                            pixels[y * MEM_W + x]  = c.colour;
                            painted[y * MEM_W + x] = 1'b1;
                        end
                    end
                    n_pixels += longint'(x1 - x0) * longint'(y1 - y0);
                    r.status = ST_FILL_DONE;
                    n_drawn++;
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [COLOUR_W-1:0] pix);
            vram_res_t e;
            n_checked++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d not expected: status %0d pixel %h", n_checked, st, pix);
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status || pix !== e.pixel) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected status %0d pixel %h, got status %0d pixel %h",
                             n_checked, e.status, e.pixel, st, pix);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                rst_n;
    logic                in_valid;
    logic                out_stall;
    vram_cmd_t           cmd_q;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [COLOUR_W-1:0] o_read_pixel;

    vram_shadow sb;
    bit feed_calm;
    bit sink_calm;
    bit hold_req;
    int quiet;
    int last_x0 = 0, last_x1 = 4, last_y0 = 0, last_y1 = 2;

    vram_rectangle_fill #(
        .MEM_WIDTH (MEM_W),
        .MEM_HEIGHT(MEM_H)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (cmd_q.action),
        .i_left      (cmd_q.left),
        .i_top       (cmd_q.top),
        .i_right     (cmd_q.right),
        .i_bottom    (cmd_q.bottom),
        .i_colour    (cmd_q.colour),
        .i_pixel_x   (cmd_q.pixel_x),
        .i_pixel_y   (cmd_q.pixel_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_status    (o_status),
        .o_read_pixel(o_read_pixel)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // both handshakes seen with their values from just before the edge
    always @(posedge i_clk) begin
        if (rst_n === 1'b1) begin
            if (in_valid === 1'b1 && o_in_stall === 1'b0)
                sb.note_command(cmd_q);
            if (o_out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(o_status, o_read_pixel);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && out_stall === 1'b0))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic vram_cmd_t fill_cmd(int l, int t, int r, int b, int col);
        vram_cmd_t c;
        c.action  = ACT_FILL;
        c.left    = X_W'(l);
        c.top     = Y_W'(t);
        c.right   = X_W'(r);
        c.bottom  = Y_W'(b);
        c.colour  = COLOUR_W'(col);
        c.pixel_x = PX_W'($urandom);
        c.pixel_y = PY_W'($urandom);
        return c;
    endfunction

    function automatic vram_cmd_t read_cmd(int x, int y);
        vram_cmd_t c;
        c         = vram_cmd_t'({$urandom, $urandom, $urandom});
        c.action  = ACT_READ;
        c.pixel_x = PX_W'(x);
        c.pixel_y = PY_W'(y);
        return c;
    endfunction

    function automatic vram_cmd_t random_fill();
        int k, l, t, r, b, rc, bc;
        k = $urandom_range(0, 99);
        l = $urandom_range(0, MEM_W - 1);
        t = $urandom_range(0, MEM_H - 1);
        if (k < 55) begin
            r = l + $urandom_range(0, 8);
            b = t + $urandom_range(0, 8);
        end else if (k < 67) begin
            r = l + $urandom_range(0, 64);
            b = t + $urandom_range(0, 16);
        end else if (k < 77) begin
            // starts near the bottom right corner and may hang off it and get clipped
            l = $urandom_range(MEM_W - 34, MEM_W - 1);
            t = $urandom_range(MEM_H - 16, MEM_H - 1);
            r = $urandom_range(l, 2047);
            b = $urandom_range(t, 1023);
        end else if (k < 80) begin
            if ($urandom_range(0, 1)) begin
                l = $urandom_range(0, 15);
                r = $urandom_range(MEM_W, 2047);
                b = t + 1;
            end else begin
                t = $urandom_range(0, 3);
                r = l + 1;
                b = $urandom_range(MEM_H, 1023);
            end
        end else begin
            r = $urandom_range(0, 2047);
            b = $urandom_range(0, 1023);
            case ($urandom_range(0, 3))
                0: begin
                    l = $urandom_range(1, 2047);
                    r = $urandom_range(0, l - 1);
                end
                1: begin
                    t = $urandom_range(1, 1023);
                    b = $urandom_range(0, t - 1);
                end
                2: l = $urandom_range(MEM_W, 2047);
                default: t = $urandom_range(MEM_H, 1023);
            endcase
        end
        rc = (r > MEM_W) ? MEM_W : r;
        bc = (b > MEM_H) ? MEM_H : b;
        if (l < rc && t < bc && l <= r && t <= b) begin
            last_x0 = l;
            last_x1 = rc;
            last_y0 = t;
            last_y1 = bc;
        end
        return fill_cmd(l, t, r, b, $urandom);
    endfunction

    function automatic vram_cmd_t random_read();
        int x, y;
        if ($urandom_range(0, 99) < 60) begin
            x = $urandom_range(last_x0, last_x1 - 1);
            y = $urandom_range(last_y0, last_y1 - 1);
        end else begin
            x = $urandom_range(0, MEM_W - 1);
            y = $urandom_range(0, MEM_H - 1);
        end
        if (!sb.painted[y * MEM_W + x]) begin
            x = last_x0;
            y = last_y0;
        end
        return read_cmd(x, y);
    endfunction

    task automatic send_cmd(input vram_cmd_t c);
        int gap;
        if ($urandom_range(0, 99) < 3) feed_calm = !feed_calm;
        gap = pick_gap(feed_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        cmd_q    <= c;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // result side stalls
    initial begin
        int n;
        out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < 3) sink_calm = !sink_calm;
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = pick_gap(sink_calm);
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin
        int i;
        sb       = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        cmd_q    <= '0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        send_cmd(fill_cmd(0, 0, 4, 2, 16'hFFFF));
        send_cmd(read_cmd(0, 0));
        send_cmd(read_cmd(3, 1));
        // empty rectangles
        send_cmd(fill_cmd(10, 5, 10, 9, 16'h1234));
        send_cmd(fill_cmd(10, 5, 14, 5, 16'h1234));
        // refused: inverted, start beyond memory
        send_cmd(fill_cmd(20, 0, 19, 4, 16'h00FF));
        send_cmd(fill_cmd(0, 7, 4, 6, 16'h00FF));
        send_cmd(fill_cmd(MEM_W, 0, 2047, 1, 16'hFF00));
        send_cmd(fill_cmd(2047, 1023, 2047, 1023, 16'hFFFF));
        send_cmd(fill_cmd(0, MEM_H, 8, 1023, 16'hFFFF));
        // clipped at the far corner
        send_cmd(fill_cmd(MEM_W - 4, MEM_H - 4, 2047, 1023, 16'h0000));
        send_cmd(read_cmd(MEM_W - 1, MEM_H - 1));
        send_cmd(fill_cmd(MEM_W - 1, MEM_H - 1, MEM_W, MEM_H, 16'hA5A5));
        send_cmd(read_cmd(MEM_W - 1, MEM_H - 1));
        send_cmd(read_cmd(MEM_W - 2, MEM_H - 2));
        // whole memory, after which every pixel is readable
        send_cmd(fill_cmd(0, 0, 2047, 1023, 16'h5A5A));
        send_cmd(read_cmd(0, 0));
        send_cmd(read_cmd(MEM_W / 2, MEM_H / 2));
        send_cmd(fill_cmd(0, 0, MEM_W, 1, 16'h0001));
        send_cmd(read_cmd(MEM_W - 1, 0));
        send_cmd(read_cmd(0, 1));
        send_cmd(read_cmd(MEM_W - 1, MEM_H - 1));

        for (i = 0; i < RANDOM_CMDS; i++) begin
            // result side holds off while items keep coming
            if (i % 500 == 250) begin
                hold_req  = 1'b1;
                feed_calm = 1'b1;
            end
            if ($urandom_range(0, 99) < 45)
                send_cmd(random_read());
            else
                send_cmd(random_fill());
        end
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d reads, %0d fills drawn over %0d pixels, %0d fills refused",
                 sb.n_reads, sb.n_drawn, sb.n_pixels, sb.n_refused);
        $display("%0d results checked, %0d wrong or unexpected", sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
design/vrf_pkg.sv
design/vrf_ram.sv
design/vrf_walker.sv
design/vram_rectangle_fill.sv
bench/vram_rectangle_fill_tb.sv
